// ----- rtl/btra_pkg.sv -----
// Shared types and constants for the boundary tag range allocator.
`timescale 1ns / 1ps
package btra_pkg;

  // Width of every address, size and byte counter field.
  localparam int unsigned DataW = 32;
  localparam int unsigned QsW   = 5;

  // Default pool dimensions.
  localparam int unsigned TagCountDef    = 256;
  localparam int unsigned BucketCountDef = 32;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned InW  = 72;
  localparam int unsigned OutW = 136;

  // Configuration register map.
  localparam int unsigned   PaddrW       = 3;
  localparam logic [2:0]    AddrQuantum  = 3'd0;
  localparam logic [QsW-1:0] QsReset     = 5'd12;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_TAG = 2'd1,
    ST_NO_FIT = 2'd2,
    ST_BAD    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_FREE  = 2'd0,
    KIND_BUSY  = 2'd1,
    KIND_SPAN  = 2'd2,
    KIND_SPARE = 2'd3
  } kind_e;

endpackage

// ----- rtl/boundary_tag_range_allocator.sv -----
// Boundary tag range allocator: tag memories, bucket heads and command sequencer.
//
// Commands arrive on the slave stream (add span, allocate, free, query size) and
// each produces exactly one result transfer on the master stream. The block
// works on one command at a time: s_axis_tready_o is high only while the
// sequencer is idle. Every tag field lives in a memory with one write port and
// one registered read port at an address shared by all fields, so list walks
// read one tag at a time. An add checks its arguments and takes two tags; an
// allocate visits buckets and walks their tags, splitting off a remainder of
// at least one quantum; a free or query scans tags in order, up to the number
// of tags ever handed out, and a free then merges free neighbours.
// Reset empties all lists and marks every tag spare; tag memories need no
// clearing pass, since tags above the high-water mark are known to be fresh.
// A result waits in the output register while the receiver stalls, and the
// sequencer holds in its final state until that register is free.
// quantum_shift is written over the APB port at address 0.
`timescale 1ns / 1ps
module boundary_tag_range_allocator #(
  parameter int unsigned TAG_COUNT    = btra_pkg::TagCountDef,
  parameter int unsigned BUCKET_COUNT = btra_pkg::BucketCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // cmd[1:0], addr[33:2], size[65:34], zero pad
  input  logic [btra_pkg::InW-1:0]    s_axis_tdata_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // status[1:0], addr_out[33:2], size_out[65:34], in_use[97:66],
  // total_size[129:98], zero pad
  output logic [btra_pkg::OutW-1:0]   m_axis_tdata_o,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [btra_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import btra_pkg::*;

  localparam int unsigned TW = $clog2(TAG_COUNT);
  localparam int unsigned LW = $clog2(TAG_COUNT + 1);
  localparam int unsigned BW = $clog2(BUCKET_COUNT);
  localparam logic [LW-1:0] TagNull = LW'(TAG_COUNT);
  localparam logic [BW-1:0] LastBucket = BW'(BUCKET_COUNT - 1);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_ADD_A = 17'h00002,
    S_ADD_B = 17'h00004,
    S_ADD_C = 17'h00008,
    S_ADD_D = 17'h00010,
    S_AL_A  = 17'h00020,
    S_AL_B  = 17'h00040,
    S_AL_R  = 17'h00080,
    S_AL_S  = 17'h00100,
    S_AL_T  = 17'h00200,
    S_FQ_S  = 17'h00400,
    S_FR_P  = 17'h00800,
    S_FR_N0 = 17'h01000,
    S_FR_N  = 17'h02000,
    S_FR_I  = 17'h04000,
    S_FR_J  = 17'h08000,
    S_DONE  = 17'h10000
  } state_e;

  function automatic logic live(input logic [LW-1:0] x);
    return x < TagNull;
  endfunction

  // Bucket index: floor(log2(len >> qs)), held at the last bucket.
  function automatic logic [BW-1:0] bucket_of(input logic [DataW:0] len,
                                               input logic [QsW-1:0] qs);
    logic [DataW:0] q;
    logic [6:0]     idx;
    q   = len >> qs;
    idx = '0;
    for (int i = 1; i <= DataW; i++) begin
      if (q[i]) idx = 7'(i);
    end
    if (idx >= 7'(BUCKET_COUNT)) return LastBucket;
    return idx[BW-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [QsW-1:0]      qs_q;
  cmd_e                cmd_q, cmd_d;
  logic [DataW-1:0]    addr_q, addr_d, size_q, size_d;
  logic [DataW:0]      req_q, req_d;
  logic [LW-1:0]       t_q, t_d, u_q, u_d, h_q, h_d, n_q, n_d;
  logic [LW-1:0]       tail_old_q, tail_old_d;
  logic [DataW-1:0]    t_start_q, t_start_d, t_len_q, t_len_d;
  logic [LW-1:0]       t_sprev_q, t_sprev_d, t_snext_q, t_snext_d;
  logic [BW-1:0]       bidx_q, bidx_d;
  logic [LW-1:0]       scan_q, scan_d;
  logic                pend_q, pend_d;
  logic [LW-1:0]       hwm_q, hwm_d;
  logic [LW-1:0]       spare_head_q, spare_head_d;
  logic [LW-1:0]       seg_tail_q, seg_tail_d;
  logic [LW-1:0]       head_q [BUCKET_COUNT];
  logic [DataW-1:0]    in_use_q, in_use_d, total_q, total_d;
  status_e             res_status_q, res_status_d;
  logic [DataW-1:0]    res_aout_q, res_aout_d, res_sout_q, res_sout_d;
  logic                m_valid_q, m_valid_d;
  logic [OutW-1:0]     m_data_q, m_data_d;

  // ---------------------------------------------------------------------
  // Tag memories, one write and one registered read per cycle each
  // ---------------------------------------------------------------------
  logic [DataW-1:0] mem_start  [TAG_COUNT];
  logic [DataW-1:0] mem_len    [TAG_COUNT];
  kind_e            mem_kind   [TAG_COUNT];
  logic [LW-1:0]    mem_sprev  [TAG_COUNT];
  logic [LW-1:0]    mem_snext  [TAG_COUNT];
  logic [LW-1:0]    mem_bprev  [TAG_COUNT];
  logic [LW-1:0]    mem_bnext  [TAG_COUNT];
  logic [LW-1:0]    mem_spnext [TAG_COUNT];

  logic [TW-1:0]    ra;
  logic [TW-1:0]    rd_idx_q;
  logic [DataW-1:0] rd_start_q, rd_len_q;
  kind_e            rd_kind_q;
  logic [LW-1:0]    rd_sprev_q, rd_snext_q, rd_bprev_q, rd_bnext_q, rd_spnext_q;

  logic             we_start, we_len, we_kind, we_sprev, we_snext;
  logic             we_bprev, we_bnext, we_spnext;
  logic [LW-1:0]    wa_start, wa_len, wa_kind, wa_sprev, wa_snext;
  logic [LW-1:0]    wa_bprev, wa_bnext, wa_spnext;
  logic [DataW-1:0] wd_start, wd_len;
  kind_e            wd_kind;
  logic [LW-1:0]    wd_sprev, wd_snext, wd_bprev, wd_bnext, wd_spnext;

  always_ff @(posedge clk_i) begin
    if (we_start)  mem_start[wa_start[TW-1:0]]   <= wd_start;
    if (we_len)    mem_len[wa_len[TW-1:0]]       <= wd_len;
    if (we_kind)   mem_kind[wa_kind[TW-1:0]]     <= wd_kind;
    if (we_sprev)  mem_sprev[wa_sprev[TW-1:0]]   <= wd_sprev;
    if (we_snext)  mem_snext[wa_snext[TW-1:0]]   <= wd_snext;
    if (we_bprev)  mem_bprev[wa_bprev[TW-1:0]]   <= wd_bprev;
    if (we_bnext)  mem_bnext[wa_bnext[TW-1:0]]   <= wd_bnext;
    if (we_spnext) mem_spnext[wa_spnext[TW-1:0]] <= wd_spnext;
    rd_start_q  <= mem_start[ra];
    rd_len_q    <= mem_len[ra];
    rd_kind_q   <= mem_kind[ra];
    rd_sprev_q  <= mem_sprev[ra];
    rd_snext_q  <= mem_snext[ra];
    rd_bprev_q  <= mem_bprev[ra];
    rd_bnext_q  <= mem_bnext[ra];
    rd_spnext_q <= mem_spnext[ra];
    rd_idx_q    <= ra;
  end

  // Tags at or above the high-water mark were never handed out: they are
  // spare and chain to the next tag.
  logic [LW-1:0] rd_idx_w;
  logic          rd_fresh;
  kind_e         rd_kind_m;
  logic [LW-1:0] rd_spn_m;

  assign rd_idx_w  = LW'(rd_idx_q);
  assign rd_fresh  = rd_idx_w >= hwm_q;
  assign rd_kind_m = rd_fresh ? KIND_SPARE : rd_kind_q;
  assign rd_spn_m  = rd_fresh ? LW'(rd_idx_w + LW'(1)) : rd_spnext_q;

  // ---------------------------------------------------------------------
  // Input decode and shared bucket-index unit
  // ---------------------------------------------------------------------
  cmd_e             in_cmd;
  logic [DataW-1:0] in_addr, in_size;
  logic [DataW:0]   q_mask, in_req, quantum;
  logic [DataW:0]   add_end, tot_sum, rd_diff;
  logic             add_bad, split;
  logic [DataW:0]   bo_in;
  logic [BW-1:0]    bo_idx;
  logic [LW-1:0]    bo_head, bidx_head;
  logic [DataW-1:0] u_len;

  assign in_cmd  = cmd_e'(s_axis_tdata_i[1:0]);
  assign in_addr = s_axis_tdata_i[33:2];
  assign in_size = s_axis_tdata_i[65:34];
  assign quantum = (DataW+1)'(1) << qs_q;
  assign q_mask  = quantum - (DataW+1)'(1);
  assign in_req  = ({1'b0, in_size} + q_mask) & ~q_mask;

  assign add_end = {1'b0, addr_q} + {1'b0, size_q} - (DataW+1)'(1);
  assign add_bad = ((size_q >> qs_q) == '0) || add_end[DataW];
  assign tot_sum = {1'b0, total_q} + {1'b0, size_q};
  assign rd_diff = {1'b0, rd_len_q} - req_q;
  assign split   = ({1'b0, rd_len_q} > req_q) && (rd_diff >= quantum);
  assign u_len   = t_len_q - req_q[DataW-1:0];

  always_comb begin
    case (state_q)
      S_AL_A:  bo_in = req_q;
      S_ADD_C: bo_in = {1'b0, size_q};
      S_AL_S:  bo_in = {1'b0, u_len};
      default: bo_in = {1'b0, t_len_q};
    endcase
  end

  assign bo_idx    = bucket_of(bo_in, qs_q);
  assign bo_head   = head_q[bo_idx];
  assign bidx_head = head_q[bidx_q];

  // Bucket head updates: one unlink or one push per cycle.
  logic          hd_rm_en, hd_ins_en;
  logic [LW-1:0] hd_rm_tag, hd_rm_nx, hd_ins_tag;
  logic [BW-1:0] hd_ins_b;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    addr_d       = addr_q;
    size_d       = size_q;
    req_d        = req_q;
    t_d          = t_q;
    u_d          = u_q;
    h_d          = h_q;
    n_d          = n_q;
    tail_old_d   = tail_old_q;
    t_start_d    = t_start_q;
    t_len_d      = t_len_q;
    t_sprev_d    = t_sprev_q;
    t_snext_d    = t_snext_q;
    bidx_d       = bidx_q;
    scan_d       = scan_q;
    pend_d       = pend_q;
    hwm_d        = hwm_q;
    spare_head_d = spare_head_q;
    seg_tail_d   = seg_tail_q;
    in_use_d     = in_use_q;
    total_d      = total_q;
    res_status_d = res_status_q;
    res_aout_d   = res_aout_q;
    res_sout_d   = res_sout_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    ra           = '0;
    we_start = 1'b0; we_len = 1'b0; we_kind = 1'b0; we_sprev = 1'b0;
    we_snext = 1'b0; we_bprev = 1'b0; we_bnext = 1'b0; we_spnext = 1'b0;
    wa_start = t_q; wa_len = t_q; wa_kind = t_q; wa_sprev = t_q;
    wa_snext = t_q; wa_bprev = t_q; wa_bnext = t_q; wa_spnext = t_q;
    wd_start = t_start_q; wd_len = t_len_q; wd_kind = KIND_FREE;
    wd_sprev = TagNull; wd_snext = TagNull; wd_bprev = TagNull;
    wd_bnext = TagNull; wd_spnext = TagNull;
    hd_rm_en = 1'b0; hd_rm_tag = TagNull; hd_rm_nx = TagNull;
    hd_ins_en = 1'b0; hd_ins_tag = TagNull; hd_ins_b = '0;

    // The output register empties when its transfer completes.
    if (m_valid_q && m_axis_tready_i) m_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d        = in_cmd;
          addr_d       = in_addr;
          size_d       = in_size;
          req_d        = in_req;
          res_status_d = ST_OK;
          res_aout_d   = '0;
          res_sout_d   = '0;
          scan_d       = '0;
          pend_d       = 1'b0;
          case (in_cmd)
            CMD_ADD:   state_d = S_ADD_A;
            CMD_ALLOC: state_d = S_AL_A;
            default:   state_d = S_FQ_S;
          endcase
        end
      end

      // Add: check arguments, then fetch the link after the spare head.
      S_ADD_A: begin
        if (add_bad) begin
          res_status_d = ST_BAD;
          state_d      = S_DONE;
        end else begin
          ra      = spare_head_q[TW-1:0];
          state_d = S_ADD_B;
        end
      end

      // Add: take the span tag and append it to the segment list.
      S_ADD_B: begin
        if (!live(spare_head_q) || !live(rd_spn_m)) begin
          res_status_d = ST_NO_TAG;
          state_d      = S_DONE;
        end else begin
          t_d          = spare_head_q;
          u_d          = rd_spn_m;
          spare_head_d = rd_spn_m;
          if (spare_head_q == hwm_q) hwm_d = LW'(hwm_q + LW'(1));
          ra           = rd_spn_m[TW-1:0];
          tail_old_d   = seg_tail_q;
          we_kind  = 1'b1; wa_kind  = spare_head_q; wd_kind  = KIND_SPAN;
          we_start = 1'b1; wa_start = spare_head_q; wd_start = addr_q;
          we_len   = 1'b1; wa_len   = spare_head_q; wd_len   = size_q;
          we_sprev = 1'b1; wa_sprev = spare_head_q; wd_sprev = seg_tail_q;
          we_snext = 1'b1; wa_snext = spare_head_q; wd_snext = rd_spn_m;
          state_d  = S_ADD_C;
        end
      end

      // Add: take the free segment tag, link it after the span and bucket it.
      S_ADD_C: begin
        spare_head_d = rd_spn_m;
        if (u_q == hwm_q) hwm_d = LW'(hwm_q + LW'(1));
        h_d        = bo_head;
        seg_tail_d = u_q;
        total_d    = tot_sum[DataW] ? '1 : tot_sum[DataW-1:0];
        we_kind  = 1'b1; wa_kind  = u_q; wd_kind  = KIND_FREE;
        we_start = 1'b1; wa_start = u_q; wd_start = addr_q;
        we_len   = 1'b1; wa_len   = u_q; wd_len   = size_q;
        we_sprev = 1'b1; wa_sprev = u_q; wd_sprev = t_q;
        we_snext = 1'b1; wa_snext = u_q; wd_snext = TagNull;
        we_bnext = 1'b1; wa_bnext = u_q; wd_bnext = bo_head;
        we_bprev = 1'b1; wa_bprev = u_q; wd_bprev = TagNull;
        hd_ins_en = 1'b1; hd_ins_b = bo_idx; hd_ins_tag = u_q;
        state_d  = S_ADD_D;
      end

      // Add: back links from the old tail and the old bucket head.
      S_ADD_D: begin
        if (live(tail_old_q)) begin
          we_snext = 1'b1; wa_snext = tail_old_q; wd_snext = t_q;
        end
        if (live(h_q)) begin
          we_bprev = 1'b1; wa_bprev = h_q; wd_bprev = u_q;
        end
        state_d = S_DONE;
      end

      // Allocate: check the request and pick the first bucket.
      S_AL_A: begin
        if (size_q == '0) begin
          res_status_d = ST_BAD;
          state_d      = S_DONE;
        end else if (!live(spare_head_q)) begin
          res_status_d = ST_NO_TAG;
          state_d      = S_DONE;
        end else begin
          bidx_d  = bo_idx;
          state_d = S_AL_B;
        end
      end

      // Allocate: start the walk of the current bucket.
      S_AL_B: begin
        if (live(bidx_head)) begin
          ra      = bidx_head[TW-1:0];
          state_d = S_AL_R;
        end else if (bidx_q == LastBucket) begin
          res_status_d = ST_NO_FIT;
          state_d      = S_DONE;
        end else begin
          bidx_d = bidx_q + BW'(1);
        end
      end

      // Allocate: one tag of the bucket list per cycle.
      S_AL_R: begin
        if ({1'b0, rd_len_q} >= req_q) begin
          t_d       = rd_idx_w;
          t_start_d = rd_start_q;
          t_len_d   = rd_len_q;
          n_d       = rd_snext_q;
          res_aout_d = rd_start_q;
          // Unlink the hit from its bucket.
          if (live(rd_bprev_q)) begin
            we_bnext = 1'b1; wa_bnext = rd_bprev_q; wd_bnext = rd_bnext_q;
          end else begin
            hd_rm_en = 1'b1; hd_rm_tag = rd_idx_w; hd_rm_nx = rd_bnext_q;
          end
          if (live(rd_bnext_q)) begin
            we_bprev = 1'b1; wa_bprev = rd_bnext_q; wd_bprev = rd_bprev_q;
          end
          we_kind = 1'b1; wa_kind = rd_idx_w; wd_kind = KIND_BUSY;
          if (split) begin
            we_len   = 1'b1; wa_len = rd_idx_w; wd_len = req_q[DataW-1:0];
            in_use_d = in_use_q + req_q[DataW-1:0];
            ra       = spare_head_q[TW-1:0];
            state_d  = S_AL_S;
          end else begin
            in_use_d = in_use_q + rd_len_q;
            state_d  = S_DONE;
          end
        end else if (live(rd_bnext_q)) begin
          ra = rd_bnext_q[TW-1:0];
        end else if (bidx_q == LastBucket) begin
          res_status_d = ST_NO_FIT;
          state_d      = S_DONE;
        end else begin
          bidx_d  = bidx_q + BW'(1);
          state_d = S_AL_B;
        end
      end

      // Allocate: the remainder becomes a new free segment after the hit.
      S_AL_S: begin
        u_d          = spare_head_q;
        spare_head_d = rd_spn_m;
        if (spare_head_q == hwm_q) hwm_d = LW'(hwm_q + LW'(1));
        h_d = bo_head;
        if (!live(n_q)) seg_tail_d = spare_head_q;
        we_kind  = 1'b1; wa_kind  = spare_head_q; wd_kind  = KIND_FREE;
        we_start = 1'b1; wa_start = spare_head_q;
        wd_start = t_start_q + req_q[DataW-1:0];
        we_len   = 1'b1; wa_len   = spare_head_q; wd_len   = u_len;
        we_sprev = 1'b1; wa_sprev = spare_head_q; wd_sprev = t_q;
        we_snext = 1'b1; wa_snext = spare_head_q; wd_snext = n_q;
        we_bnext = 1'b1; wa_bnext = spare_head_q; wd_bnext = bo_head;
        we_bprev = 1'b1; wa_bprev = spare_head_q; wd_bprev = TagNull;
        hd_ins_en = 1'b1; hd_ins_b = bo_idx; hd_ins_tag = spare_head_q;
        state_d  = S_AL_T;
      end

      // Allocate: finish the links around the remainder.
      S_AL_T: begin
        we_snext = 1'b1; wa_snext = t_q; wd_snext = u_q;
        if (live(n_q)) begin
          we_sprev = 1'b1; wa_sprev = n_q; wd_sprev = u_q;
        end
        if (live(h_q)) begin
          we_bprev = 1'b1; wa_bprev = h_q; wd_bprev = u_q;
        end
        state_d = S_DONE;
      end

      // Free or query: scan tags in ascending order for a busy exact match.
      S_FQ_S: begin
        if (pend_q && rd_kind_m == KIND_BUSY && rd_start_q == addr_q) begin
          t_d        = rd_idx_w;
          t_start_d  = rd_start_q;
          t_len_d    = rd_len_q;
          t_sprev_d  = rd_sprev_q;
          t_snext_d  = rd_snext_q;
          res_sout_d = rd_len_q;
          if (cmd_q == CMD_QUERY) begin
            state_d = S_DONE;
          end else begin
            in_use_d = in_use_q - rd_len_q;
            if (live(rd_sprev_q)) begin
              ra      = rd_sprev_q[TW-1:0];
              state_d = S_FR_P;
            end else begin
              state_d = S_FR_N0;
            end
          end
        end else if (scan_q < hwm_q) begin
          ra     = scan_q[TW-1:0];
          scan_d = LW'(scan_q + LW'(1));
          pend_d = 1'b1;
        end else begin
          res_status_d = ST_BAD;
          state_d      = S_DONE;
        end
      end

      // Free: merge a free predecessor and return its tag.
      S_FR_P: begin
        if (rd_kind_m == KIND_FREE) begin
          if (live(rd_sprev_q)) begin
            we_snext = 1'b1; wa_snext = rd_sprev_q; wd_snext = t_q;
          end
          if (live(rd_bprev_q)) begin
            we_bnext = 1'b1; wa_bnext = rd_bprev_q; wd_bnext = rd_bnext_q;
          end else begin
            hd_rm_en = 1'b1; hd_rm_tag = rd_idx_w; hd_rm_nx = rd_bnext_q;
          end
          if (live(rd_bnext_q)) begin
            we_bprev = 1'b1; wa_bprev = rd_bnext_q; wd_bprev = rd_bprev_q;
          end
          we_spnext = 1'b1; wa_spnext = rd_idx_w; wd_spnext = spare_head_q;
          we_kind   = 1'b1; wa_kind   = rd_idx_w; wd_kind   = KIND_SPARE;
          spare_head_d = rd_idx_w;
          t_sprev_d    = rd_sprev_q;
          t_len_d      = t_len_q + rd_len_q;
          t_start_d    = rd_start_q;
        end
        state_d = S_FR_N0;
      end

      // Free: fetch the successor once the predecessor writes have landed.
      S_FR_N0: begin
        if (live(t_snext_q)) begin
          ra      = t_snext_q[TW-1:0];
          state_d = S_FR_N;
        end else begin
          state_d = S_FR_I;
        end
      end

      // Free: merge a free successor and return its tag.
      S_FR_N: begin
        if (rd_kind_m == KIND_FREE) begin
          t_snext_d = rd_snext_q;
          if (live(rd_snext_q)) begin
            we_sprev = 1'b1; wa_sprev = rd_snext_q; wd_sprev = t_q;
          end else begin
            seg_tail_d = t_q;
          end
          if (live(rd_bprev_q)) begin
            we_bnext = 1'b1; wa_bnext = rd_bprev_q; wd_bnext = rd_bnext_q;
          end else begin
            hd_rm_en = 1'b1; hd_rm_tag = rd_idx_w; hd_rm_nx = rd_bnext_q;
          end
          if (live(rd_bnext_q)) begin
            we_bprev = 1'b1; wa_bprev = rd_bnext_q; wd_bprev = rd_bprev_q;
          end
          we_spnext = 1'b1; wa_spnext = rd_idx_w; wd_spnext = spare_head_q;
          we_kind   = 1'b1; wa_kind   = rd_idx_w; wd_kind   = KIND_SPARE;
          spare_head_d = rd_idx_w;
          t_len_d      = t_len_q + rd_len_q;
        end
        state_d = S_FR_I;
      end

      // Free: write back the merged segment and push it on its bucket.
      S_FR_I: begin
        h_d      = bo_head;
        we_kind  = 1'b1; wd_kind  = KIND_FREE;
        we_start = 1'b1; wd_start = t_start_q;
        we_len   = 1'b1; wd_len   = t_len_q;
        we_sprev = 1'b1; wd_sprev = t_sprev_q;
        we_snext = 1'b1; wd_snext = t_snext_q;
        we_bnext = 1'b1; wd_bnext = bo_head;
        we_bprev = 1'b1; wd_bprev = TagNull;
        hd_ins_en = 1'b1; hd_ins_b = bo_idx; hd_ins_tag = t_q;
        state_d  = S_FR_J;
      end

      S_FR_J: begin
        if (live(h_q)) begin
          we_bprev = 1'b1; wa_bprev = h_q; wd_bprev = t_q;
        end
        state_d = S_DONE;
      end

      // Load the result once the output register is free.
      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {6'b0, total_q, in_use_q, res_sout_q, res_aout_q,
                       res_status_q};
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control and payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      qs_q         <= QsReset;
      hwm_q        <= '0;
      spare_head_q <= '0;
      seg_tail_q   <= TagNull;
      in_use_q     <= '0;
      total_q      <= '0;
      m_valid_q    <= 1'b0;
      pend_q       <= 1'b0;
      for (int b = 0; b < BUCKET_COUNT; b++) head_q[b] <= TagNull;
    end else begin
      state_q      <= state_d;
      hwm_q        <= hwm_d;
      spare_head_q <= spare_head_d;
      seg_tail_q   <= seg_tail_d;
      in_use_q     <= in_use_d;
      total_q      <= total_d;
      m_valid_q    <= m_valid_d;
      pend_q       <= pend_d;
      if (psel && penable && pwrite && pready && paddr == AddrQuantum) begin
        qs_q <= pwdata[QsW-1:0];
      end
      for (int b = 0; b < BUCKET_COUNT; b++) begin
        if (hd_rm_en && head_q[b] == hd_rm_tag) head_q[b] <= hd_rm_nx;
        if (hd_ins_en && hd_ins_b == BW'(b)) head_q[b] <= hd_ins_tag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    addr_q       <= addr_d;
    size_q       <= size_d;
    req_q        <= req_d;
    t_q          <= t_d;
    u_q          <= u_d;
    h_q          <= h_d;
    n_q          <= n_d;
    tail_old_q   <= tail_old_d;
    t_start_q    <= t_start_d;
    t_len_q      <= t_len_d;
    t_sprev_q    <= t_sprev_d;
    t_snext_q    <= t_snext_d;
    bidx_q       <= bidx_d;
    scan_q       <= scan_d;
    res_status_q <= res_status_d;
    res_aout_q   <= res_aout_d;
    res_sout_q   <= res_sout_d;
    m_data_q     <= m_data_d;
  end

  // ---------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign pready          = 1'b1;
  assign prdata          = (paddr == AddrQuantum) ? 32'(qs_q) : 32'd0;

endmodule

// ----- rtl/btra_checker.sv -----
// Port-level checker for the boundary tag range allocator, with its bind.
`timescale 1ns / 1ps
module btra_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic [btra_pkg::OutW-1:0]   m_axis_tdata_o,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i
);
  import btra_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // Each command keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("command accepted back to back");

  // A failed command reports no address and no size.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] != ST_OK |->
      m_axis_tdata_o[65:2] == '0)
    else $error("failed command carries data");

  // The saturating total size never drops from one result to the next.
  a_total_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i |=>
      !m_axis_tvalid_o || m_axis_tdata_o[129:98] >= $past(m_axis_tdata_o[129:98]))
    else $error("total size decreased");

endmodule

bind boundary_tag_range_allocator btra_checker u_btra_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);
